// ===== sv/cfm_pkg.sv =====
// Shared types, constants and color tables of the cell false color mapper.
package cfm_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_RENDER_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEA_LEVEL   = 2'd1;

    localparam logic [2:0] MODE_RANDOM = 3'd0;
    localparam logic [2:0] MODE_HEIGHT = 3'd1;
    localparam logic [2:0] MODE_COAST  = 3'd2;
    localparam logic [2:0] MODE_TEMP   = 3'd3;
    localparam logic [2:0] MODE_PRECIP = 3'd4;

    localparam logic [2:0]  RESET_RENDER_MODE = 3'd5;
    localparam logic [15:0] RESET_SEA_LEVEL   = 16'd26214;

    localparam logic [15:0] SEA_FLOOR   = 16'd655;
    localparam logic [17:0] TEMP_OFFSET = 18'd7680;
    localparam logic [15:0] TEMP_SPAN   = 16'd16640;
    localparam logic [15:0] PRECIP_MAX  = 16'd15000;
    localparam logic [23:0] HASH_MULT   = 24'h3779B1;
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [3:0]  BIOME_RIVER = 4'd14;

    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = 16 / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef enum logic [1:0] {
        PAIR_WATER  = 2'd0,
        PAIR_LAND   = 2'd1,
        PAIR_TEMP   = 2'd2,
        PAIR_PRECIP = 2'd3
    } pair_t;

    typedef struct packed {
        logic        ramp;
        rgb_t        rgb;
        pair_t       pair;
        logic        use_div;
        logic [16:0] t_dir;
    } side_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] den;
        logic [15:0] quo;
    } div_t;

    typedef struct packed {
        side_t side;
        div_t  div;
    } item_t;

    localparam rgb_t COLOR_WATER = '{red: 8'd45, green: 8'd85, blue: 8'd150};
    localparam rgb_t COLOR_COAST = '{red: 8'd210, green: 8'd195, blue: 8'd140};

    function automatic rgb_t ramp_lo(input pair_t pair);
        rgb_t c;
        case (pair)
            PAIR_WATER:  c = '{red: 8'd10, green: 8'd20, blue: 8'd60};
            PAIR_LAND:   c = '{red: 8'd110, green: 8'd150, blue: 8'd80};
            PAIR_TEMP:   c = '{red: 8'd40, green: 8'd60, blue: 8'd200};
            default:     c = '{red: 8'd200, green: 8'd180, blue: 8'd120};
        endcase
        return c;
    endfunction

    function automatic rgb_t ramp_hi(input pair_t pair);
        rgb_t c;
        case (pair)
            PAIR_WATER:  c = '{red: 8'd60, green: 8'd110, blue: 8'd170};
            PAIR_LAND:   c = '{red: 8'd120, green: 8'd95, blue: 8'd70};
            PAIR_TEMP:   c = '{red: 8'd220, green: 8'd60, blue: 8'd40};
            default:     c = '{red: 8'd30, green: 8'd90, blue: 8'd50};
        endcase
        return c;
    endfunction

    function automatic rgb_t biome_color(input logic [3:0] code);
        rgb_t c;
        case (code)
            4'd0:    c = '{red: 8'd38, green: 8'd78, blue: 8'd140};
            4'd1:    c = '{red: 8'd235, green: 8'd245, blue: 8'd250};
            4'd2:    c = '{red: 8'd200, green: 8'd205, blue: 8'd210};
            4'd3:    c = '{red: 8'd150, green: 8'd165, blue: 8'd150};
            4'd4:    c = '{red: 8'd190, green: 8'd180, blue: 8'd150};
            4'd5:    c = '{red: 8'd190, green: 8'd185, blue: 8'd110};
            4'd6:    c = '{red: 8'd150, green: 8'd180, blue: 8'd90};
            4'd7:    c = '{red: 8'd70, green: 8'd130, blue: 8'd70};
            4'd8:    c = '{red: 8'd40, green: 8'd100, blue: 8'd60};
            4'd9:    c = '{red: 8'd220, green: 8'd200, blue: 8'd130};
            4'd10:   c = '{red: 8'd190, green: 8'd185, blue: 8'd90};
            4'd11:   c = '{red: 8'd90, green: 8'd150, blue: 8'd60};
            4'd12:   c = '{red: 8'd30, green: 8'd110, blue: 8'd40};
            4'd13:   c = '{red: 8'd235, green: 8'd215, blue: 8'd140};
            4'd14:   c = '{red: 8'd60, green: 8'd120, blue: 8'd200};
            default: c = '{red: 8'd255, green: 8'd0, blue: 8'd255};
        endcase
        return c;
    endfunction

endpackage

// ===== sv/cfm_prep.sv =====
// First pipeline stage: mode decode, fixed colors, hash, and ramp fraction setup.
module cfm_prep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           render_mode,
    input  logic [15:0]          sea_level,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [23:0]          cell_index,
    input  logic [15:0]          height,
    input  logic signed [15:0]   temperature,
    input  logic [15:0]          precipitation,
    input  logic                 is_water,
    input  logic                 is_coast,
    input  logic                 is_river,
    input  logic [3:0]           biome_code,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cfm_pkg::item_t       out_item
);

    logic            valid_reg;
    cfm_pkg::item_t  item_reg;
    cfm_pkg::item_t  item_next;
    logic [23:0]     hash;
    logic [24:0]     grey_sum;
    logic [15:0]     sea_eff;
    logic signed [17:0] temp_n;
    logic [15:0]     temp_num;
    logic [15:0]     precip_num;
    logic [15:0]     num;
    logic [15:0]     den;
    logic            advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign hash     = 24'(cell_index * cfm_pkg::HASH_MULT);
    assign grey_sum = {1'b0, height, 8'd0} - {9'd0, height} + 25'd32768;
    assign sea_eff  = (sea_level < cfm_pkg::SEA_FLOOR) ? cfm_pkg::SEA_FLOOR : sea_level;
    assign temp_n   = 18'(signed'(temperature)) + signed'(cfm_pkg::TEMP_OFFSET);

    always_comb
    begin
        if (temp_n < 18'sd0)
        begin
            temp_num = 16'd0;
        end
        else if (temp_n > signed'({2'b00, cfm_pkg::TEMP_SPAN}))
        begin
            temp_num = cfm_pkg::TEMP_SPAN;
        end
        else
        begin
            temp_num = temp_n[15:0];
        end
        precip_num = (precipitation > cfm_pkg::PRECIP_MAX) ? cfm_pkg::PRECIP_MAX
                                                           : precipitation;
    end

    always_comb
    begin
        item_next            = '0;
        num                  = height;
        den                  = sea_eff;
        item_next.side.pair  = cfm_pkg::PAIR_WATER;
        unique case (render_mode)
            cfm_pkg::MODE_RANDOM:
            begin
                item_next.side.rgb.red   = hash[7:0];
                item_next.side.rgb.green = hash[15:8];
                item_next.side.rgb.blue  = hash[23:16];
            end
            cfm_pkg::MODE_HEIGHT:
            begin
                if (is_water)
                begin
                    item_next.side.ramp = 1'b1;
                    item_next.side.pair = cfm_pkg::PAIR_WATER;
                end
                else
                begin
                    item_next.side.rgb.red   = grey_sum[23:16];
                    item_next.side.rgb.green = grey_sum[23:16];
                    item_next.side.rgb.blue  = grey_sum[23:16];
                end
            end
            cfm_pkg::MODE_COAST:
            begin
                if (is_water)
                begin
                    item_next.side.rgb = cfm_pkg::COLOR_WATER;
                end
                else if (is_coast)
                begin
                    item_next.side.rgb = cfm_pkg::COLOR_COAST;
                end
                else
                begin
                    item_next.side.ramp = 1'b1;
                    item_next.side.pair = cfm_pkg::PAIR_LAND;
                end
            end
            cfm_pkg::MODE_TEMP:
            begin
                item_next.side.ramp = 1'b1;
                item_next.side.pair = cfm_pkg::PAIR_TEMP;
                num                 = temp_num;
                den                 = cfm_pkg::TEMP_SPAN;
            end
            cfm_pkg::MODE_PRECIP:
            begin
                if (is_water)
                begin
                    item_next.side.rgb = cfm_pkg::COLOR_WATER;
                end
                else
                begin
                    item_next.side.ramp = 1'b1;
                    item_next.side.pair = cfm_pkg::PAIR_PRECIP;
                    num                 = precip_num;
                    den                 = cfm_pkg::PRECIP_MAX;
                end
            end
            default:
            begin
                item_next.side.rgb = cfm_pkg::biome_color(is_river ? cfm_pkg::BIOME_RIVER
                                                                   : biome_code);
            end
        endcase

        if (render_mode == cfm_pkg::MODE_COAST)
        begin
            item_next.side.use_div = 1'b0;
            item_next.side.t_dir   = {1'b0, height};
        end
        else if (num >= den)
        begin
            item_next.side.use_div = 1'b0;
            item_next.side.t_dir   = cfm_pkg::ONE_Q16;
        end
        else
        begin
            item_next.side.use_div = 1'b1;
            item_next.side.t_dir   = '0;
        end
        item_next.div.rem = num;
        item_next.div.den = den;
        item_next.div.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/cfm_div_stage.sv =====
// One divider stage: four restoring quotient bits of the ramp fraction per cycle when not stalled.
module cfm_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cfm_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output cfm_pkg::item_t  out_item
);

    logic            valid_reg;
    cfm_pkg::item_t  item_reg;
    cfm_pkg::item_t  item_next;
    logic            advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        logic [16:0] shifted;
        logic [15:0] rem;
        logic [15:0] quo;
        rem = in_item.div.rem;
        quo = in_item.div.quo;
        for (int k = 0; k < cfm_pkg::DIV_BITS_PER_STAGE; k++)
        begin
            shifted = {rem, 1'b0};
            if (shifted >= {1'b0, in_item.div.den})
            begin
                rem = 16'(shifted - {1'b0, in_item.div.den});
                quo = {quo[14:0], 1'b1};
            end
            else
            begin
                rem = shifted[15:0];
                quo = {quo[14:0], 1'b0};
            end
        end
        item_next         = in_item;
        item_next.div.rem = rem;
        item_next.div.quo = quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/cfm_lerp.sv =====
// Last two stages: ramp products per channel, then the rounded blend and output register.
module cfm_lerp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cfm_pkg::item_t       in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cfm_pkg::rgb_t        out_rgb
);

    logic                mul_valid_reg;
    logic                mul_ramp_reg;
    cfm_pkg::rgb_t       mul_rgb_reg;
    cfm_pkg::rgb_t       mul_lo_reg;
    logic signed [26:0]  prod_r_reg;
    logic signed [26:0]  prod_g_reg;
    logic signed [26:0]  prod_b_reg;
    logic                out_valid_reg;
    cfm_pkg::rgb_t       out_rgb_reg;
    cfm_pkg::rgb_t       out_rgb_next;
    logic [16:0]         t;
    cfm_pkg::rgb_t       lo;
    cfm_pkg::rgb_t       hi;
    logic                out_advance;
    logic                mul_advance;

    assign out_advance = !out_valid_reg || out_ready;
    assign mul_advance = !mul_valid_reg || out_advance;
    assign in_ready    = mul_advance;
    assign out_valid   = out_valid_reg;
    assign out_rgb     = out_rgb_reg;

    assign t  = in_item.side.use_div ? {1'b0, in_item.div.quo} : in_item.side.t_dir;
    assign lo = cfm_pkg::ramp_lo(in_item.side.pair);
    assign hi = cfm_pkg::ramp_hi(in_item.side.pair);

    function automatic logic signed [26:0] mul_ch(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [16:0] frac);
        logic signed [8:0] d;
        d = signed'({1'b0, b}) - signed'({1'b0, a});
        return 27'(d * signed'({1'b0, frac}));
    endfunction

    function automatic logic [7:0] blend_ch(input logic [7:0] a,
                                            input logic signed [26:0] prod);
        logic signed [26:0] s;
        s = signed'({3'b000, a, 16'd0}) + prod + 27'sd32768;
        return s[23:16];
    endfunction

    always_comb
    begin
        if (mul_ramp_reg)
        begin
            out_rgb_next.red   = blend_ch(mul_lo_reg.red, prod_r_reg);
            out_rgb_next.green = blend_ch(mul_lo_reg.green, prod_g_reg);
            out_rgb_next.blue  = blend_ch(mul_lo_reg.blue, prod_b_reg);
        end
        else
        begin
            out_rgb_next = mul_rgb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_advance)
            begin
                mul_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_advance && in_valid)
        begin
            mul_ramp_reg <= in_item.side.ramp;
            mul_rgb_reg  <= in_item.side.rgb;
            mul_lo_reg   <= lo;
            prod_r_reg   <= mul_ch(lo.red, hi.red, t);
            prod_g_reg   <= mul_ch(lo.green, hi.green, t);
            prod_b_reg   <= mul_ch(lo.blue, hi.blue, t);
        end
        if (out_advance && mul_valid_reg)
        begin
            out_rgb_reg <= out_rgb_next;
        end
    end

endmodule

// ===== sv/cell_false_color_mapper.sv =====
// Top level of the cell false color mapper: configuration registers and pipeline.
//
// Each input item carries one map cell and yields one RGB item under the selected render
// mode. The block accepts one item per clock unless the output stalls. In the pipeline,
// one stage decodes the mode and sets up the ramp fraction, four stages each produce
// four quotient bits of the ramp fraction (height over sea level, or the clamped
// temperature or precipitation over its span), one stage forms the per-channel ramp
// products, and the output register adds and rounds. Stalls from the output side back
// up stage by stage, so bubbles still fill while a result waits. Write the configuration
// registers only while no item is in flight.
module cell_false_color_mapper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cfm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cfm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cell_index[23:0], height[39:24], temperature[55:40], precipitation[71:56],
    // biome_code[75:72], zeros[79:76].
    input  logic [79:0]                   s_axis_tdata,
    // is_water[0], is_coast[1], is_river[2].
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // red[7:0], green[15:8], blue[23:16].
    output logic [23:0]                   m_axis_tdata
);

    logic [2:0]                      render_mode_reg;
    logic [15:0]                     sea_level_reg;
    logic [cfm_pkg::DIV_STAGES:0]    stg_valid;
    logic [cfm_pkg::DIV_STAGES:0]    stg_ready;
    cfm_pkg::item_t                  stg_item [cfm_pkg::DIV_STAGES+1];
    cfm_pkg::rgb_t                   rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_mode_reg <= cfm_pkg::RESET_RENDER_MODE;
            sea_level_reg   <= cfm_pkg::RESET_SEA_LEVEL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cfm_pkg::CFG_RENDER_MODE: render_mode_reg <= cfg_data[2:0];
                cfm_pkg::CFG_SEA_LEVEL:   sea_level_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    cfm_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .render_mode   (render_mode_reg),
        .sea_level     (sea_level_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .cell_index    (s_axis_tdata[23:0]),
        .height        (s_axis_tdata[39:24]),
        .temperature   (signed'(s_axis_tdata[55:40])),
        .precipitation (s_axis_tdata[71:56]),
        .is_water      (s_axis_tuser[0]),
        .is_coast      (s_axis_tuser[1]),
        .is_river      (s_axis_tuser[2]),
        .biome_code    (s_axis_tdata[75:72]),
        .out_valid     (stg_valid[0]),
        .out_ready     (stg_ready[0]),
        .out_item      (stg_item[0])
    );

    for (genvar i = 0; i < cfm_pkg::DIV_STAGES; i++)
    begin : g_div
        cfm_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_item   (stg_item[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_item  (stg_item[i+1])
        );
    end

    cfm_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[cfm_pkg::DIV_STAGES]),
        .in_ready  (stg_ready[cfm_pkg::DIV_STAGES]),
        .in_item   (stg_item[cfm_pkg::DIV_STAGES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rgb   (rgb)
    );

    assign m_axis_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule
